[hdl/bsc_pkg.sv]
`timescale 1ns / 1ps

package bsc_pkg;

   // field and datapath widths
   localparam int COORD_W     = 32;   // Q16.16 coordinate or matrix entry
   localparam int FRAC_W      = 16;
   localparam int PROD_W      = 48;   // product after the floor to 16 fraction bits, Q32.16
   localparam int SUM_W       = 50;   // clip-space sum, signed
   localparam int MAG_W       = 49;   // magnitude of a clip sum
   localparam int QUO_W       = 31;   // NDC magnitude below saturation
   localparam int NDC_W       = 32;
   localparam int SPAN_W      = 34;
   localparam int COV_W       = 17;
   localparam int REG_W       = 64;
   localparam int REG_IDX_W   = 3;
   localparam int NUM_REGS    = 6;
   localparam int NUM_ROWS    = 3;
   localparam int NUM_AXES    = 3;
   localparam int NUM_CORNERS = 8;
   localparam int NUM_LANES   = 16;   // x and y of every corner
   localparam int IN_W        = 192;
   localparam int OUT_W       = 24;

   // quotient bits resolved in each divider stage
   localparam int DIV_STEPS_DEFAULT = 2;

   // clip w at or below this raw value counts as behind the camera
   localparam int W_THRESHOLD = 7;
   localparam int ONE_Q16     = 65536;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_ROW_X_COLS01 = 3'd0,
      REG_ROW_X_COLS23 = 3'd1,
      REG_ROW_Y_COLS01 = 3'd2,
      REG_ROW_Y_COLS23 = 3'd3,
      REG_ROW_W_COLS01 = 3'd4,
      REG_ROW_W_COLS23 = 3'd5
   } csr_index_type;

   localparam logic [REG_W-1:0] RESET_ROW_X_COLS01 = 64'h0000_0000_0001_0000;
   localparam logic [REG_W-1:0] RESET_ROW_X_COLS23 = 64'h0000_0000_0000_0000;
   localparam logic [REG_W-1:0] RESET_ROW_Y_COLS01 = 64'h0001_0000_0000_0000;
   localparam logic [REG_W-1:0] RESET_ROW_Y_COLS23 = 64'h0000_0000_0000_0000;
   localparam logic [REG_W-1:0] RESET_ROW_W_COLS01 = 64'h0000_0000_0000_0000;
   localparam logic [REG_W-1:0] RESET_ROW_W_COLS23 = 64'h0001_0000_0000_0000;

   // side flags of one divider lane
   typedef struct packed {
      logic neg;   // numerator was negative
      logic ovf;   // quotient reaches 2^31, saturate
   } div_flags_type;

endpackage

[hdl/bsc_div_lane.sv]
`timescale 1ns / 1ps

module bsc_div_lane #(
   parameter int STEPS_PER_STAGE = bsc_pkg::DIV_STEPS_DEFAULT,
   localparam int QUO_W      = bsc_pkg::QUO_W,
   localparam int NUM_STAGES = (QUO_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE
) (
   input  logic                              clock,
   input  logic [NUM_STAGES:0]               stage_en,
   input  logic signed [bsc_pkg::SUM_W-1:0]  num,
   input  logic signed [bsc_pkg::SUM_W-1:0]  den,
   output logic [QUO_W-1:0]                  quot,
   output bsc_pkg::div_flags_type            flags
);

   localparam int SUM_W    = bsc_pkg::SUM_W;
   localparam int MAG_W    = bsc_pkg::MAG_W;
   localparam int FRAC_W   = bsc_pkg::FRAC_W;
   localparam int HI_SHIFT = QUO_W - FRAC_W;

   logic [MAG_W-1:0]       rem_ff  [NUM_STAGES+1];
   logic [MAG_W-1:0]       rem_in  [NUM_STAGES+1];
   logic [QUO_W-1:0]       qd_ff   [NUM_STAGES+1];
   logic [QUO_W-1:0]       qd_in   [NUM_STAGES+1];
   logic [MAG_W-1:0]       dv_ff   [NUM_STAGES+1];
   logic [MAG_W-1:0]       dv_in   [NUM_STAGES+1];
   bsc_pkg::div_flags_type fl_ff   [NUM_STAGES+1];
   bsc_pkg::div_flags_type fl_in   [NUM_STAGES+1];

   // entry: magnitude, overflow test, first partial remainder
   // later stages: restoring steps, quotient bits shift in from the right
   always_comb begin
      logic [SUM_W-1:0] mag;
      logic [MAG_W-1:0] r;
      logic [QUO_W-1:0] q;
      logic [MAG_W:0]   t;
      logic [MAG_W:0]   diff;
      mag = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
      fl_in[0].neg = num[SUM_W-1];
      dv_in[0]     = den[MAG_W-1:0];
      rem_in[0]    = {{HI_SHIFT{1'b0}}, mag[MAG_W-1:HI_SHIFT]};
      qd_in[0]     = {mag[HI_SHIFT-1:0], {FRAC_W{1'b0}}};
      fl_in[0].ovf = (rem_in[0] >= dv_in[0]);
      for (int j = 1; j <= NUM_STAGES; j++) begin
         r = rem_ff[j-1];
         q = qd_ff[j-1];
         for (int i = 0; i < STEPS_PER_STAGE; i++) begin
            if ((j - 1) * STEPS_PER_STAGE + i < QUO_W) begin
               t    = {r, q[QUO_W-1]};
               diff = t - {1'b0, dv_ff[j-1]};
               if (t >= {1'b0, dv_ff[j-1]}) begin
                  r = diff[MAG_W-1:0];
                  q = {q[QUO_W-2:0], 1'b1};
               end else begin
                  r = t[MAG_W-1:0];
                  q = {q[QUO_W-2:0], 1'b0};
               end
            end
         end
         rem_in[j] = r;
         qd_in[j]  = q;
         dv_in[j]  = dv_ff[j-1];
         fl_in[j]  = fl_ff[j-1];
      end
   end

   // advance each stage when the pipeline lets it
   always_ff @(posedge clock) begin
      for (int j = 0; j <= NUM_STAGES; j++) begin
         if (stage_en[j]) begin
            rem_ff[j] <= rem_in[j];
            qd_ff[j]  <= qd_in[j];
            dv_ff[j]  <= dv_in[j];
            fl_ff[j]  <= fl_in[j];
         end
      end
   end

   assign quot  = qd_ff[NUM_STAGES];
   assign flags = fl_ff[NUM_STAGES];

endmodule

[hdl/box_screen_coverage.sv]
`timescale 1ns / 1ps
// The restoring NDC divider lanes and DIV_STEPS_PER_STAGE set the pipeline depth.
// Throughput: one box per cycle; every stage holds one word and a stall backs up only
//   as far as the first empty stage.
// Reset: synchronous, active high; clears all valid bits and loads the camera rows
//   with their defaults. Configuration writes are taken in every cycle outside reset.

module box_screen_coverage #(
   parameter int DIV_STEPS_PER_STAGE = bsc_pkg::DIV_STEPS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bsc_pkg::IN_W-1:0]          req_tdata,
   // coverage[16:0], zero pad
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bsc_pkg::OUT_W-1:0]         rsp_tdata,
   // behind_camera
   output logic                              rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bsc_pkg::REG_IDX_W-1:0]     csr_addr,
   input  logic [bsc_pkg::REG_W-1:0]         csr_data
);

   localparam int COORD_W  = bsc_pkg::COORD_W;
   localparam int FRAC_W   = bsc_pkg::FRAC_W;
   localparam int PROD_W   = bsc_pkg::PROD_W;
   localparam int SUM_W    = bsc_pkg::SUM_W;
   localparam int QUO_W    = bsc_pkg::QUO_W;
   localparam int NDC_W    = bsc_pkg::NDC_W;
   localparam int SPAN_W   = bsc_pkg::SPAN_W;
   localparam int COV_W    = bsc_pkg::COV_W;
   localparam int OUT_W    = bsc_pkg::OUT_W;
   localparam int NROW     = bsc_pkg::NUM_ROWS;
   localparam int NAX      = bsc_pkg::NUM_AXES;
   localparam int NCOR     = bsc_pkg::NUM_CORNERS;
   localparam int NLANE    = bsc_pkg::NUM_LANES;
   localparam int NDS      = (QUO_W + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;
   localparam int NV       = NDS + 5;
   localparam int V_L0     = 2;
   localparam int V_N      = NV - 2;
   localparam int V_R      = NV - 1;
   localparam int NBEH     = NDS + 3;
   localparam int W_ROW    = 2;

   localparam logic signed [NDC_W-1:0] NDC_ONE  = NDC_W'(bsc_pkg::ONE_Q16);
   localparam logic signed [NDC_W-1:0] NDC_MONE = -NDC_W'(bsc_pkg::ONE_Q16);
   localparam logic signed [NDC_W-1:0] NDC_MAX  = {1'b0, {(NDC_W-1){1'b1}}};
   localparam logic signed [NDC_W-1:0] NDC_MIN  = {1'b1, {(NDC_W-1){1'b0}}};

   logic [bsc_pkg::REG_W-1:0] csr_regs_ff [bsc_pkg::NUM_REGS];

   logic [NV-1:0] v_ff;
   logic [NV-1:0] en;
   logic          out_en;
   logic          rsp_valid_ff;

   logic signed [PROD_W-1:0] prod_ff [NROW][NAX][2];
   logic signed [PROD_W-1:0] prod_in [NROW][NAX][2];
   logic signed [SUM_W-1:0]  sum_ff  [NCOR][NROW];
   logic signed [SUM_W-1:0]  sum_in  [NCOR][NROW];

   logic                     beh_ff  [NBEH];
   logic                     beh0;

   logic [QUO_W-1:0]         quot    [NLANE];
   bsc_pkg::div_flags_type   flags   [NLANE];

   logic signed [NDC_W-1:0]  ndc_ff  [NLANE];
   logic signed [NDC_W-1:0]  ndc_in  [NLANE];
   logic signed [NDC_W-1:0]  left_ff, right_ff, bottom_ff, top_ff;
   logic signed [NDC_W-1:0]  left_in, right_in, bottom_in, top_in;

   logic [COV_W-1:0]         cov_ff;
   logic [COV_W-1:0]         cov_in;
   logic                     user_ff;

   // configuration: always ready, writes past the last register drop
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_regs_ff[bsc_pkg::REG_ROW_X_COLS01] <= bsc_pkg::RESET_ROW_X_COLS01;
         csr_regs_ff[bsc_pkg::REG_ROW_X_COLS23] <= bsc_pkg::RESET_ROW_X_COLS23;
         csr_regs_ff[bsc_pkg::REG_ROW_Y_COLS01] <= bsc_pkg::RESET_ROW_Y_COLS01;
         csr_regs_ff[bsc_pkg::REG_ROW_Y_COLS23] <= bsc_pkg::RESET_ROW_Y_COLS23;
         csr_regs_ff[bsc_pkg::REG_ROW_W_COLS01] <= bsc_pkg::RESET_ROW_W_COLS01;
         csr_regs_ff[bsc_pkg::REG_ROW_W_COLS23] <= bsc_pkg::RESET_ROW_W_COLS23;
      end else if (csr_valid) begin
         case (csr_addr)
            bsc_pkg::REG_ROW_X_COLS01, bsc_pkg::REG_ROW_X_COLS23,
            bsc_pkg::REG_ROW_Y_COLS01, bsc_pkg::REG_ROW_Y_COLS23,
            bsc_pkg::REG_ROW_W_COLS01, bsc_pkg::REG_ROW_W_COLS23: begin
               csr_regs_ff[csr_addr] <= csr_data;
            end
            default: ;
         endcase
      end
   end

   // stage enables: a stage moves when it is empty or the next one moves
   always_comb begin
      out_en     = !rsp_valid_ff || rsp_tready;
      en[NV-1]   = !v_ff[NV-1] || out_en;
      for (int i = NV - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign req_tready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < NV; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
         if (out_en) begin
            rsp_valid_ff <= v_ff[NV-1];
         end
      end
   end

   // products: each entry of columns 0 to 2 times the low and high coordinate, floored to Q32.16
   always_comb begin
      logic signed [COORD_W-1:0]   ent;
      logic signed [COORD_W-1:0]   crd;
      logic signed [2*COORD_W-1:0] prod;
      for (int r = 0; r < NROW; r++) begin
         for (int c = 0; c < NAX; c++) begin
            for (int s = 0; s < 2; s++) begin
               ent  = csr_regs_ff[r*2 + (c >> 1)][COORD_W*(c & 1) +: COORD_W];
               crd  = req_tdata[(s*NAX + c)*COORD_W +: COORD_W];
               prod = ent * crd;
               prod_in[r][c][s] = prod[2*COORD_W-1:FRAC_W];
            end
         end
      end
   end

   // corner sums: column 3 plus the three picked products
   always_comb begin
      logic signed [COORD_W-1:0] ent3;
      for (int k = 0; k < NCOR; k++) begin
         for (int r = 0; r < NROW; r++) begin
            ent3 = csr_regs_ff[r*2 + 1][2*COORD_W-1:COORD_W];
            sum_in[k][r] = SUM_W'(ent3)
                         + SUM_W'(prod_ff[r][0][k & 1])
                         + SUM_W'(prod_ff[r][1][(k >> 1) & 1])
                         + SUM_W'(prod_ff[r][2][(k >> 2) & 1]);
         end
      end
   end

   // behind test on the registered w sums
   always_comb begin
      beh0 = 1'b0;
      for (int k = 0; k < NCOR; k++) begin
         if (sum_ff[k][W_ROW] <= $signed(SUM_W'(bsc_pkg::W_THRESHOLD))) begin
            beh0 = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prod_ff <= prod_in;
      end
      if (en[1]) begin
         sum_ff <= sum_in;
      end
      if (en[V_L0]) begin
         beh_ff[0] <= beh0;
      end
      for (int i = 1; i < NBEH; i++) begin
         if (en[V_L0 + i]) begin
            beh_ff[i] <= beh_ff[i-1];
         end
      end
   end

   // NDC dividers: lane 2k is x of corner k, lane 2k+1 is y
   for (genvar k = 0; k < NCOR; k++) begin : g_corner
      for (genvar a = 0; a < 2; a++) begin : g_axis
         bsc_div_lane #(
            .STEPS_PER_STAGE (DIV_STEPS_PER_STAGE)
         ) u_div (
            .clock    (clock),
            .stage_en (en[V_L0 +: NDS+1]),
            .num      (sum_ff[k][a]),
            .den      (sum_ff[k][W_ROW]),
            .quot     (quot[k*2 + a]),
            .flags    (flags[k*2 + a])
         );
      end
   end

   // sign and saturate the quotients
   always_comb begin
      logic signed [NDC_W-1:0] mag;
      for (int l = 0; l < NLANE; l++) begin
         mag = $signed({1'b0, quot[l]});
         if (flags[l].ovf) begin
            ndc_in[l] = flags[l].neg ? NDC_MIN : NDC_MAX;
         end else begin
            ndc_in[l] = flags[l].neg ? -mag : mag;
         end
      end
   end

   // bounding rectangle as a min/max tree over the corners, seeded at +1.0 / -1.0
   always_comb begin
      logic signed [NDC_W-1:0] lo_x [NCOR];
      logic signed [NDC_W-1:0] hi_x [NCOR];
      logic signed [NDC_W-1:0] lo_y [NCOR];
      logic signed [NDC_W-1:0] hi_y [NCOR];
      for (int k = 0; k < NCOR; k++) begin
         lo_x[k] = ndc_ff[2*k];
         hi_x[k] = ndc_ff[2*k];
         lo_y[k] = ndc_ff[2*k + 1];
         hi_y[k] = ndc_ff[2*k + 1];
      end
      // fold the upper half onto the lower half at each level
      for (int w = NCOR >> 1; w >= 1; w = w >> 1) begin
         for (int k = 0; k < w; k++) begin
            if (lo_x[k + w] < lo_x[k]) lo_x[k] = lo_x[k + w];
            if (hi_x[k + w] > hi_x[k]) hi_x[k] = hi_x[k + w];
            if (lo_y[k + w] < lo_y[k]) lo_y[k] = lo_y[k + w];
            if (hi_y[k + w] > hi_y[k]) hi_y[k] = hi_y[k + w];
         end
      end
      left_in   = (lo_x[0] < NDC_ONE)  ? lo_x[0] : NDC_ONE;
      right_in  = (hi_x[0] > NDC_MONE) ? hi_x[0] : NDC_MONE;
      bottom_in = (lo_y[0] < NDC_ONE)  ? lo_y[0] : NDC_ONE;
      top_in    = (hi_y[0] > NDC_MONE) ? hi_y[0] : NDC_MONE;
   end

   // coverage: half the larger span, clamped; behind forces full coverage
   always_comb begin
      logic signed [SPAN_W-1:0] spx;
      logic signed [SPAN_W-1:0] spy;
      logic signed [SPAN_W-1:0] span;
      logic [SPAN_W-1:0]        half;
      spx  = SPAN_W'(right_ff) - SPAN_W'(left_ff);
      spy  = SPAN_W'(top_ff) - SPAN_W'(bottom_ff);
      span = (spy > spx) ? spy : spx;
      if (span < 0) begin
         span = '0;
      end
      half = SPAN_W'(span) >> 1;
      if (beh_ff[NBEH-1] || half > SPAN_W'(bsc_pkg::ONE_Q16)) begin
         cov_in = COV_W'(bsc_pkg::ONE_Q16);
      end else begin
         cov_in = half[COV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[V_N]) begin
         ndc_ff <= ndc_in;
      end
      if (en[V_R]) begin
         left_ff   <= left_in;
         right_ff  <= right_in;
         bottom_ff <= bottom_in;
         top_ff    <= top_in;
      end
      if (out_en) begin
         cov_ff  <= cov_in;
         user_ff <= beh_ff[NBEH-1];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(OUT_W-COV_W){1'b0}}, cov_ff};
   assign rsp_tuser  = user_ff;

`ifndef SYNTHESIS
   // behind camera always reports full coverage
   a_behind_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> cov_ff == COV_W'(bsc_pkg::ONE_Q16))
      else $error("behind word without full coverage");

   // coverage never passes the whole screen
   a_cov_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> cov_ff <= COV_W'(bsc_pkg::ONE_Q16))
      else $error("coverage above one");

   // input backs up only behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output backpressure");

   // an accepted box reaches the product stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> v_ff[0])
      else $error("accepted box lost at entry");
`endif

endmodule
